@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising edge of clk outside reset
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/dlt_pkg.sv @@
// ---------------------------------------------------------------------------
// dlt_pkg
// Types and constants shared by the frame builder modules.
// ---------------------------------------------------------------------------
package dlt_pkg;

	// frame framing characters and protocol constants
	localparam logic [7:0]  START_CHAR       = 8'h68;
	localparam logic [7:0]  END_CHAR         = 8'h16;
	localparam logic [15:0] FIXED_USER_BYTES = 16'd12;
	localparam logic [15:0] BCAST_BCD        = 16'h9999;
	localparam logic [1:0]  PROTO_RESET      = 2'd2;
	localparam int          MAX_PAYLOAD_DEF  = 1024;

	// port widths
	localparam int TDATA_W = 120;
	localparam int LEN_W   = 11;
	localparam int PROTO_W = 2;

	// byte positions inside a header run
	localparam int IDX_W        = 5;
	localparam logic [IDX_W-1:0] IDX_FIRST_SUM = 5'd6;
	localparam logic [IDX_W-1:0] IDX_LAST_HDR  = 5'd17;
	localparam logic [IDX_W-1:0] IDX_END_HDR   = 5'd19;
	// byte positions inside a data run
	localparam logic [IDX_W-1:0] IDX_DATA_SUM  = 5'd1;
	localparam logic [IDX_W-1:0] IDX_DATA_END  = 5'd2;

	typedef logic [IDX_W-1:0] idx_t;

	// one unpacked input request
	typedef struct packed {
		logic             is_header;
		logic [7:0]       control_byte;
		logic [15:0]      area_code_bcd;
		logic [15:0]      terminal_code_bcd;
		logic [6:0]       master_address;
		logic [7:0]       function_code;
		logic [7:0]       sequence_byte;
		logic [15:0]      point_id;
		logic [15:0]      item_id;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       payload_byte;
	} item_t;

	// one output byte with its markers
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       run_last;
		logic       frame_last;
	} beat_t;

	// handoff from byte generator to output register
	typedef struct packed {
		logic  push;
		beat_t beat;
	} beat_req_t;

endpackage

@@ hw/rtl/dlt_in_stage.sv @@
// ---------------------------------------------------------------------------
// dlt_in_stage
// Input register: unpacks the request and saturates the payload length.
// ---------------------------------------------------------------------------
module dlt_in_stage #(
	parameter int MAX_PAYLOAD = dlt_pkg::MAX_PAYLOAD_DEF,
	parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dlt_pkg::TDATA_W-1:0]   s_tdata,
	input  logic                          s_tuser,
	input  logic                          consume,
	output logic                          valid_s1,
	output dlt_pkg::item_t                item_s1,
	output logic [CNT_W-1:0]              len_sat_s1
);
	import dlt_pkg::*;

	item_t            item_d;
	logic [CNT_W-1:0] len_sat_d;
	logic             take;

	// field unpacking, lowest field first
	always_comb begin
		item_d.is_header         = s_tuser;
		item_d.control_byte      = s_tdata[7:0];
		item_d.area_code_bcd     = s_tdata[23:8];
		item_d.terminal_code_bcd = s_tdata[39:24];
		item_d.master_address    = s_tdata[46:40];
		item_d.function_code     = s_tdata[54:47];
		item_d.sequence_byte     = s_tdata[62:55];
		item_d.point_id          = s_tdata[78:63];
		item_d.item_id           = s_tdata[94:79];
		item_d.payload_length    = s_tdata[105:95];
		item_d.payload_byte      = s_tdata[113:106];
	end

	// clamp length to the largest payload
	always_comb begin
		if (32'(item_d.payload_length) > 32'(MAX_PAYLOAD)) begin
			len_sat_d = CNT_W'(MAX_PAYLOAD);
		end else begin
			len_sat_d = CNT_W'(item_d.payload_length);
		end
	end

	// stage is free when empty or its request finishes this cycle
	assign s_tready = !valid_s1 || consume;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1    <= item_d;
			len_sat_s1 <= len_sat_d;
		end
	end

endmodule

@@ hw/rtl/dlt_byte_gen.sv @@
// ---------------------------------------------------------------------------
// dlt_byte_gen
// Walks the byte positions of the staged request and keeps frame state.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dlt_byte_gen #(
	parameter int MAX_PAYLOAD = dlt_pkg::MAX_PAYLOAD_DEF,
	parameter int CNT_W       = $clog2(MAX_PAYLOAD + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  dlt_pkg::item_t                item_s1,
	input  logic [CNT_W-1:0]              len_sat_s1,
	input  logic [dlt_pkg::PROTO_W-1:0]   protocol_bits,
	input  logic                          space,
	output logic                          consume,
	output dlt_pkg::beat_req_t            req
);
	import dlt_pkg::*;

	idx_t             idx_q;
	logic             in_frame_q;
	logic [CNT_W-1:0] bytes_left_q;
	logic [7:0]       sum_q;

	logic             hdr;
	logic             drop;
	logic             closes;
	idx_t             last_idx;
	logic             run_last;
	logic             summed;
	logic             frame_last;
	logic [7:0]       byte_val;
	logic [7:0]       hdr_byte;
	logic [15:0]      len_field;
	logic [7:0]       a3;
	logic             emit;

	assign hdr  = item_s1.is_header;
	assign drop = !hdr && !in_frame_q;

	// length field and third address byte
	assign len_field = 16'((FIXED_USER_BYTES + 16'(len_sat_s1)) << 2)
		| 16'(protocol_bits);
	assign a3 = {item_s1.master_address,
		(item_s1.area_code_bcd == BCAST_BCD) && (item_s1.terminal_code_bcd == BCAST_BCD)};

	// run length: header closes at once when empty, data closes on its last byte
	always_comb begin
		if (hdr) begin
			closes   = (len_sat_s1 == '0);
			last_idx = closes ? IDX_END_HDR : IDX_LAST_HDR;
		end else begin
			closes   = (idx_q != '0) || (bytes_left_q <= CNT_W'(1));
			last_idx = closes ? IDX_DATA_END : '0;
		end
	end

	assign run_last = (idx_q == last_idx);

	// header byte select
	always_comb begin
		case (idx_q)
			5'd0:    hdr_byte = START_CHAR;
			5'd1:    hdr_byte = len_field[7:0];
			5'd2:    hdr_byte = len_field[15:8];
			5'd3:    hdr_byte = len_field[7:0];
			5'd4:    hdr_byte = len_field[15:8];
			5'd5:    hdr_byte = START_CHAR;
			5'd6:    hdr_byte = item_s1.control_byte;
			5'd7:    hdr_byte = item_s1.area_code_bcd[15:8];
			5'd8:    hdr_byte = item_s1.area_code_bcd[7:0];
			5'd9:    hdr_byte = item_s1.terminal_code_bcd[15:8];
			5'd10:   hdr_byte = item_s1.terminal_code_bcd[7:0];
			5'd11:   hdr_byte = a3;
			5'd12:   hdr_byte = item_s1.function_code;
			5'd13:   hdr_byte = item_s1.sequence_byte;
			5'd14:   hdr_byte = item_s1.point_id[7:0];
			5'd15:   hdr_byte = item_s1.point_id[15:8];
			5'd16:   hdr_byte = item_s1.item_id[7:0];
			5'd17:   hdr_byte = item_s1.item_id[15:8];
			5'd18:   hdr_byte = sum_q;
			default: hdr_byte = END_CHAR;
		endcase
	end

	// final byte, checksum coverage and frame end marker
	always_comb begin
		if (hdr) begin
			byte_val   = hdr_byte;
			summed     = (idx_q >= IDX_FIRST_SUM) && (idx_q <= IDX_LAST_HDR);
			frame_last = (idx_q == IDX_END_HDR);
		end else begin
			if (idx_q == '0) begin
				byte_val = item_s1.payload_byte;
			end else if (idx_q == IDX_DATA_SUM) begin
				byte_val = sum_q;
			end else begin
				byte_val = END_CHAR;
			end
			summed     = (idx_q == '0);
			frame_last = (idx_q == IDX_DATA_END);
		end
	end

	assign emit    = valid_s1 && !drop && space;
	assign consume = valid_s1 && (drop || (space && run_last));

	assign req.push            = emit;
	assign req.beat.frame_byte = byte_val;
	assign req.beat.run_last   = run_last;
	assign req.beat.frame_last = frame_last;

	// position counter and frame state, advanced once per byte sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
			sum_q        <= '0;
		end else if (emit) begin
			idx_q <= run_last ? '0 : idx_q + idx_t'(1);
			if (hdr && idx_q == '0) begin
				sum_q <= '0;
			end else if (summed) begin
				sum_q <= sum_q + byte_val;
			end
			if (frame_last) begin
				in_frame_q   <= 1'b0;
				bytes_left_q <= '0;
			end else if (idx_q == '0) begin
				if (hdr) begin
					in_frame_q   <= 1'b1;
					bytes_left_q <= len_sat_s1;
				end else begin
					bytes_left_q <= bytes_left_q - CNT_W'(1);
				end
			end
		end
	end

	`ASSERT_IMPLY(a_end_is_run_last, emit && frame_last, run_last,
		"closing byte must end its run")
	`ASSERT_CLK(a_idx_range, idx_q <= IDX_END_HDR, "byte position out of range")
	`ASSERT_IMPLY(a_open_has_bytes, in_frame_q && idx_q == '0, bytes_left_q != '0,
		"open frame with no payload left between runs")
	`ASSERT_IMPLY(a_drop_at_start, valid_s1 && drop, idx_q == '0,
		"stray data byte dropped in the middle of a run")

endmodule

@@ hw/rtl/dlt_out_reg.sv @@
// ---------------------------------------------------------------------------
// dlt_out_reg
// Output register for the master-side byte stream.
// ---------------------------------------------------------------------------
module dlt_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  dlt_pkg::beat_req_t  req,
	output logic                space,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);
	import dlt_pkg::*;

	beat_t beat_q;

	// register can load when empty or being drained
	assign space = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (space) begin
			m_tvalid <= req.push;
		end
	end

	always_ff @(posedge clk) begin
		if (space && req.push) begin
			beat_q <= req.beat;
		end
	end

	assign m_tdata = beat_q.frame_byte;
	assign m_tlast = beat_q.frame_last;
	assign m_tuser = beat_q.run_last;

endmodule

@@ hw/rtl/dlt3761_frame_builder_core.sv @@
// ---------------------------------------------------------------------------
// dlt3761_frame_builder_core
// Builds DL/T 376.1 style frames as a byte stream from header and data requests.
// ---------------------------------------------------------------------------
// channel  | dir | tdata                         | tuser      | tlast
// s_*      | in  | header fields and payload_byte| is_header  | -
// m_*      | out | frame_byte                    | run_last   | frame_last
// cfg_*    | in  | protocol_bits (write only)    | -          | -
//
// A data request gives one byte per cycle, three when it closes the frame, none outside a frame.
// A header request gives 18 bytes, 20 with an empty payload, one per cycle.
// Throughput is set by the output register: one byte leaves per cycle unless m_tready is low.
// s_tready rises in the cycle the staged request sends its last byte, so data
// requests follow back to back; a header or a closing data request holds the
// input until its last byte is sent. m_tready low stalls both stages.
// A staged request's bytes pass through the output register. Reset is asynchronous.
// ---------------------------------------------------------------------------
module dlt3761_frame_builder_core #(
	parameter int MAX_PAYLOAD = dlt_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// control_byte, area_code_bcd, terminal_code_bcd, master_address,
	// function_code, sequence_byte, point_id, item_id, payload_length,
	// payload_byte, zero fill
	input  logic [dlt_pkg::TDATA_W-1:0]  s_tdata,
	input  logic                         s_tuser,   // is_header
	// master side
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // frame_byte
	output logic                         m_tuser,   // run_last
	output logic                         m_tlast,   // frame_last
	// configuration
	input  logic                         cfg_we,
	input  logic [dlt_pkg::PROTO_W-1:0]  cfg_wdata
);
	import dlt_pkg::*;

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	logic [PROTO_W-1:0] proto_q;
	logic               valid_s1;
	item_t              item_s1;
	logic [CNT_W-1:0]   len_sat_s1;
	logic               consume;
	logic               space;
	beat_req_t          req;

	// protocol bits register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q <= PROTO_RESET;
		end else if (cfg_we) begin
			proto_q <= cfg_wdata;
		end
	end

	dlt_in_stage #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.CNT_W       (CNT_W)
	) u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.consume    (consume),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.len_sat_s1 (len_sat_s1)
	);

	dlt_byte_gen #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.CNT_W       (CNT_W)
	) u_byte_gen (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.len_sat_s1    (len_sat_s1),
		.protocol_bits (proto_q),
		.space         (space),
		.consume       (consume),
		.req           (req)
	);

	dlt_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
